/* design/ab2lp_pkg.sv */
// Shared types and constants of the Annex-B to length-prefixed NAL converter.
package ab2lp_pkg;

  // Capacity of the converted-unit store in bytes.
  localparam int UNIT_BYTES = 65536;

  localparam int AddrW       = $clog2(UNIT_BYTES);
  localparam int PtrW        = AddrW + 1;
  localparam int ExtW        = PtrW + 1;
  localparam int LenW        = 17;
  localparam int CntW        = 32;
  localparam int HeldW       = 2;
  localparam int PrefixBytes = 4;
  localparam int PrefixW     = $clog2(PrefixBytes);
  localparam int MaxEmit     = 4;
  localparam int EmitW       = $clog2(MaxEmit + 1);
  localparam int StepW       = $clog2(MaxEmit + PrefixBytes + 1);
  localparam int QDepth      = 4;
  localparam int QPtrW       = $clog2(QDepth);

  localparam logic [HeldW-1:0] HeldMax   = 2'd3;
  localparam logic [HeldW-1:0] HeldStart = 2'd2;
  localparam logic [7:0]       StartByte = 8'h01;

  localparam logic ActWrite = 1'b0;
  localparam logic ActRead  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0]      out_byte;
    logic            out_valid;
    logic            out_last;
    logic [LenW-1:0] unit_length;
    logic            overflow;
    logic            refused;
  } out_t;

  // One classified request for the back end: stores, prefix patch, read.
  typedef struct packed {
    logic             is_read;
    logic [AddrW-1:0] rd_addr;
    logic [EmitW-1:0] n_emit;
    logic [ExtW-1:0]  ebase;
    logic [7:0]       last_val;
    logic             patch;
    logic [PtrW-1:0]  pbase;
    logic [CntW-1:0]  pcount;
    out_t             res;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DONE
  } back_state_e;

endpackage

/* design/ab2lp_ram.sv */
// Generic single-port-write, registered-read RAM.
module ab2lp_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/ab2lp_front.sv */
// Front end: accepts requests, parses start codes and books store space.
module ab2lp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  ab2lp_pkg::in_t    in_req_i,
  input  logic              q_full_i,
  output logic              in_stall_o,
  output ab2lp_pkg::push_t  push_o
);

  logic [ab2lp_pkg::HeldW-1:0] held_q, held_d;
  logic                        open_q, open_d;
  logic                        fresh_q, fresh_d;
  logic [ab2lp_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [ab2lp_pkg::PtrW-1:0]  pp_q, pp_d;
  logic [ab2lp_pkg::PtrW-1:0]  wp_q, wp_d;
  logic [ab2lp_pkg::PtrW-1:0]  rp_q, rp_d;
  logic                        ready_q, ready_d;
  logic                        ovf_q, ovf_d;

  logic                        accept;
  logic                        is_zero, is_sc;
  logic [ab2lp_pkg::HeldW-1:0] held_nx;
  logic [ab2lp_pkg::EmitW-1:0] n_raw, eff_n;
  logic [7:0]                  last_val;
  logic                        pref;
  logic [ab2lp_pkg::ExtW-1:0]  ebase, total;
  logic                        over;
  logic [ab2lp_pkg::PtrW-1:0]  wp_new, pp_new;
  logic                        ovf_new;
  logic [ab2lp_pkg::CntW-1:0]  cnt_base, cnt_new;
  logic [ab2lp_pkg::CntW:0]    csum;
  logic                        fresh_new;
  logic [ab2lp_pkg::PtrW-1:0]  rp_inc;
  logic                        rd_ok, rd_end;
  ab2lp_pkg::cmd_t             cmd;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  // Zero-run tracking and emission count for one write byte.
  always_comb begin
    is_zero  = (in_req_i.in_byte == 8'd0);
    is_sc    = (in_req_i.in_byte == ab2lp_pkg::StartByte) && (held_q >= ab2lp_pkg::HeldStart);
    held_nx  = held_q;
    n_raw    = '0;
    last_val = 8'd0;
    if (is_zero) begin
      if (held_q != ab2lp_pkg::HeldMax) begin
        held_nx = held_q + ab2lp_pkg::HeldW'(1);
      end else begin
        n_raw = ab2lp_pkg::EmitW'(1);
      end
    end else if (is_sc) begin
      held_nx = '0;
    end else begin
      n_raw    = ab2lp_pkg::EmitW'(held_q) + ab2lp_pkg::EmitW'(1);
      held_nx  = '0;
      last_val = in_req_i.in_byte;
    end
    // Flush held zeros into the open NAL at the end of the unit.
    if (in_req_i.in_last) begin
      n_raw   = n_raw + ab2lp_pkg::EmitW'(held_nx);
      held_nx = '0;
    end

    eff_n    = open_q ? n_raw : '0;
    pref     = fresh_q && (eff_n != '0);
    ebase    = ab2lp_pkg::ExtW'(wp_q)
             + (pref ? ab2lp_pkg::ExtW'(ab2lp_pkg::PrefixBytes) : '0);
    total    = ebase + ab2lp_pkg::ExtW'(eff_n);
    over     = total > ab2lp_pkg::ExtW'(ab2lp_pkg::UNIT_BYTES);
    wp_new   = over ? ab2lp_pkg::PtrW'(ab2lp_pkg::UNIT_BYTES) : total[ab2lp_pkg::PtrW-1:0];
    ovf_new  = ovf_q || over;
    pp_new   = pref ? wp_q : pp_q;
    cnt_base = pref ? '0 : cnt_q;
    csum     = {1'b0, cnt_base} + (ab2lp_pkg::CntW + 1)'(eff_n);
    cnt_new  = csum[ab2lp_pkg::CntW] ? '1 : csum[ab2lp_pkg::CntW-1:0];
    fresh_new = fresh_q && !pref;

    rp_inc = rp_q + ab2lp_pkg::PtrW'(1);
    rd_ok  = ready_q && (rp_q < wp_q);
    rd_end = (rp_inc == wp_q);
  end

  // Classify the request, build the back-end command, advance the state.
  always_comb begin
    held_d  = held_q;
    open_d  = open_q;
    fresh_d = fresh_q;
    cnt_d   = cnt_q;
    pp_d    = pp_q;
    wp_d    = wp_q;
    rp_d    = rp_q;
    ready_d = ready_q;
    ovf_d   = ovf_q;
    cmd     = '0;

    if (in_req_i.action == ab2lp_pkg::ActRead) begin
      cmd.is_read = rd_ok;
      cmd.rd_addr = rp_q[ab2lp_pkg::AddrW-1:0];
      if (rd_ok) begin
        cmd.res.out_valid   = 1'b1;
        cmd.res.out_last    = rd_end;
        cmd.res.unit_length = ab2lp_pkg::LenW'(wp_q);
        cmd.res.overflow    = ovf_q;
        if (accept) begin
          rp_d = rp_inc;
          if (rd_end) begin
            ready_d = 1'b0;
            wp_d    = '0;
            rp_d    = '0;
            ovf_d   = 1'b0;
          end
        end
      end
    end else if (ready_q) begin
      cmd.res.refused     = 1'b1;
      cmd.res.unit_length = ab2lp_pkg::LenW'(wp_q);
      cmd.res.overflow    = ovf_q;
    end else begin
      cmd.n_emit   = eff_n;
      cmd.ebase    = ebase;
      cmd.last_val = last_val;
      if (is_sc) begin
        // Close the previous NAL: patch its prefix with the final count.
        cmd.patch  = open_q && !fresh_q;
        cmd.pbase  = pp_q;
        cmd.pcount = cnt_q;
      end else begin
        cmd.patch  = in_req_i.in_last && open_q && !fresh_new;
        cmd.pbase  = pp_new;
        cmd.pcount = cnt_new;
      end
      if (in_req_i.in_last) begin
        cmd.res.unit_length = ab2lp_pkg::LenW'(wp_new);
        cmd.res.overflow    = ovf_new;
      end
      if (accept) begin
        held_d  = held_nx;
        wp_d    = wp_new;
        ovf_d   = ovf_new;
        pp_d    = pp_new;
        cnt_d   = cnt_new;
        fresh_d = fresh_new;
        if (is_sc) begin
          open_d  = 1'b1;
          fresh_d = 1'b1;
        end
        if (in_req_i.in_last) begin
          open_d  = 1'b0;
          fresh_d = 1'b0;
          cnt_d   = '0;
          held_d  = '0;
          pp_d    = '0;
          rp_d    = '0;
          ready_d = (wp_new != '0);
          ovf_d   = (wp_new != '0) ? ovf_new : 1'b0;
        end
      end
    end
  end

  assign push_o.push = accept;
  assign push_o.cmd  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      open_q  <= 1'b0;
      fresh_q <= 1'b0;
      cnt_q   <= '0;
      pp_q    <= '0;
      wp_q    <= '0;
      rp_q    <= '0;
      ready_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      held_q  <= held_d;
      open_q  <= open_d;
      fresh_q <= fresh_d;
      cnt_q   <= cnt_d;
      pp_q    <= pp_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      ready_q <= ready_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

/* design/ab2lp_queue.sv */
// Short command queue between the front and back ends.
module ab2lp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ab2lp_pkg::push_t push_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output ab2lp_pkg::cmd_t  head_o
);

  ab2lp_pkg::cmd_t              entry_q [ab2lp_pkg::QDepth];
  logic [ab2lp_pkg::QPtrW-1:0]  wr_q, wr_d;
  logic [ab2lp_pkg::QPtrW-1:0]  rd_q, rd_d;
  logic [ab2lp_pkg::QPtrW:0]    cnt_q, cnt_d;
  logic                         do_push, do_pop;

  assign full_o  = (cnt_q == (ab2lp_pkg::QPtrW + 1)'(ab2lp_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entry_q[rd_q];
  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + ab2lp_pkg::QPtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + ab2lp_pkg::QPtrW'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (ab2lp_pkg::QPtrW + 1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (ab2lp_pkg::QPtrW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= push_i.cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* design/ab2lp_back.sv */
// Back end: carries out stores, prefix patches and reads on the unit store.
module ab2lp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  ab2lp_pkg::cmd_t q_head_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ab2lp_pkg::out_t out_req_o
);

  ab2lp_pkg::back_state_e         state_q, state_d;
  ab2lp_pkg::cmd_t                cmd_q, cmd_d;
  logic [ab2lp_pkg::StepW-1:0]    step_q, step_d;
  logic                           out_valid_q, out_valid_d;
  ab2lp_pkg::out_t                out_q, out_d;

  logic [ab2lp_pkg::StepW-1:0]    n_ops, n_emit;
  logic                           is_emit, op_left;
  logic [ab2lp_pkg::PrefixW-1:0]  pk;
  logic [ab2lp_pkg::ExtW-1:0]     waddr_ext;
  logic [ab2lp_pkg::CntW-1:0]     shifted;
  logic [7:0]                     wdata, rdata;
  logic                           we, re, out_free, load_out;

  assign n_emit  = ab2lp_pkg::StepW'(cmd_q.n_emit);
  assign n_ops   = n_emit + (cmd_q.patch ? ab2lp_pkg::StepW'(ab2lp_pkg::PrefixBytes) : '0);
  assign is_emit = step_q < n_emit;
  assign op_left = step_q < n_ops;
  assign pk      = ab2lp_pkg::PrefixW'(step_q - n_emit);

  // Address and data of the current store: payload first, then prefix bytes.
  always_comb begin
    shifted = cmd_q.pcount >> {ab2lp_pkg::PrefixW'(ab2lp_pkg::PrefixBytes - 1) - pk, 3'b000};
    if (is_emit) begin
      waddr_ext = cmd_q.ebase + ab2lp_pkg::ExtW'(step_q);
      wdata     = (step_q + ab2lp_pkg::StepW'(1) == n_emit) ? cmd_q.last_val : 8'd0;
    end else begin
      waddr_ext = ab2lp_pkg::ExtW'(cmd_q.pbase) + ab2lp_pkg::ExtW'(pk);
      wdata     = shifted[7:0];
    end
  end

  // Drop stores that fall beyond capacity.
  assign we = (state_q == ab2lp_pkg::BK_RUN) && op_left
           && (waddr_ext < ab2lp_pkg::ExtW'(ab2lp_pkg::UNIT_BYTES));
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    step_d   = step_q;
    q_pop_o  = 1'b0;
    re       = 1'b0;
    load_out = 1'b0;
    case (state_q)
      ab2lp_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_head_i;
          step_d  = '0;
          state_d = ab2lp_pkg::BK_RUN;
        end
      end
      ab2lp_pkg::BK_RUN: begin
        if (op_left) begin
          step_d = step_q + ab2lp_pkg::StepW'(1);
        end else begin
          re      = cmd_q.is_read;
          state_d = ab2lp_pkg::BK_DONE;
        end
      end
      ab2lp_pkg::BK_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          if (!q_empty_i) begin
            q_pop_o = 1'b1;
            cmd_d   = q_head_i;
            step_d  = '0;
            state_d = ab2lp_pkg::BK_RUN;
          end else begin
            state_d = ab2lp_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_d = ab2lp_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = load_out || (out_valid_q && out_stall_i);
    out_d       = out_q;
    if (load_out) begin
      out_d          = cmd_q.res;
      out_d.out_byte = cmd_q.is_read ? rdata : 8'd0;
    end
  end

  ab2lp_ram #(
    .Width (8),
    .Depth (ab2lp_pkg::UNIT_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr_ext[ab2lp_pkg::AddrW-1:0]),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (cmd_q.rd_addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    step_q <= step_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ab2lp_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

/* design/annexb_to_length_prefixed_nal.sv */
// Annex-B to length-prefixed NAL converter, top level.
// A request passes from the front end through the command queue to the back end, which does
// its store bytes (0 to 8: up to 4 payload bytes and a 4-byte prefix), then gives its result.
// The back end handles one request at a time and does its store bytes one by one, since the
// unit store has a single write port.
// Reset: asynchronous, active low; clears parser, pointers, queue and output valid. The store
// holds no reset value and needs no clearing pass.
module annexb_to_length_prefixed_nal (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ab2lp_pkg::in_t  in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ab2lp_pkg::out_t out_req_o
);

  // Front-to-queue request and queue status.
  ab2lp_pkg::push_t push;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  ab2lp_pkg::cmd_t  q_head;

  // Front: track the zero run, spot start codes, book store space and
  // decide refusals and read results. One request per cycle while the
  // queue has room.
  ab2lp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push)
  );

  // Queue: hold classified requests so the front keeps going while the
  // back end writes prefixes or waits on a stalled output.
  ab2lp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  // Back: store payload bytes, patch length prefixes when a NAL closes,
  // read converted bytes, and present one result per request.
  ab2lp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule
